@@ rtl/kfr_pkg.sv @@
// ============================================================================
// KISS frame receiver package
// Shared widths, byte codes, event codes and the queue word type.
// ============================================================================
package kfr_pkg;

  // Number of serial links served and the frame length limit.
  localparam int NUM_LINKS   = 4;
  localparam int FRAME_LIMIT = 512;

  // Field widths of the channels.
  localparam int LINK_W    = 4;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int PORT_W    = 8;
  localparam int ID_W      = 16;

  // Per-link state widths.
  localparam int LINK_IDX_W = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int COUNT_W    = $clog2(FRAME_LIMIT + 1);

  // KISS special bytes.
  localparam logic [BYTE_W-1:0] CH_FEND  = 8'hC0;
  localparam logic [BYTE_W-1:0] CH_FESC  = 8'hDB;
  localparam logic [BYTE_W-1:0] CH_TFEND = 8'hDC;
  localparam logic [BYTE_W-1:0] CH_TFESC = 8'hDD;

  // Command nibbles.
  localparam logic [3:0] CMD_DATA = 4'd0;
  localparam logic [3:0] CMD_ACK  = 4'd12;

  // Receive modes.
  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_PAYLOAD = 3'd0;
  localparam logic [KIND_W-1:0] EV_END     = 3'd1;
  localparam logic [KIND_W-1:0] EV_OVERRUN = 3'd2;
  localparam logic [KIND_W-1:0] EV_SHORT   = 3'd3;
  localparam logic [KIND_W-1:0] EV_UNKNOWN = 3'd4;
  localparam logic [KIND_W-1:0] EV_BADESC  = 3'd5;

  // Classified byte as it travels from the front end to the back end.
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [BYTE_W-1:0] rx_byte;
    logic              is_fend;
    logic              is_fesc;
    logic              is_tfend;
    logic              is_tfesc;
  } kfr_word_t;

endpackage

@@ rtl/kfr_if.sv @@
// ============================================================================
// KISS frame receiver channels
// Valid/ready interfaces for the received byte and the event word.
// ============================================================================

// Received byte channel.
interface kfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [kfr_pkg::LINK_W-1:0] link;
  logic [kfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output link, output rx_byte, input ready);
  modport sink   (input valid, input link, input rx_byte, output ready);
endinterface

// Event channel.
interface kfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [kfr_pkg::KIND_W-1:0] event_kind;
  logic [kfr_pkg::PORT_W-1:0] port;
  logic [kfr_pkg::BYTE_W-1:0] payload_byte;
  logic                      is_ackmode;
  logic [kfr_pkg::ID_W-1:0]   frame_id;

  modport source (output valid, output event_kind, output port, output payload_byte,
                  output is_ackmode, output frame_id, input ready);
  modport sink   (input valid, input event_kind, input port, input payload_byte,
                  input is_ackmode, input frame_id, output ready);
endinterface

@@ rtl/kfr_front.sv @@
// ============================================================================
// KISS frame receiver front end
// Accepts received bytes, drops those of unserved links, flags the KISS
// special bytes and holds the result in a two-word queue.
// ============================================================================
module kfr_front (
  input  logic               clk,
  input  logic               rst_n,
  kfr_in_if.sink             in_ch,
  output logic               q_valid,
  output kfr_pkg::kfr_word_t q_word,
  input  logic               q_pop
);
  import kfr_pkg::*;

  kfr_word_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       accept;
  logic       push;
  logic       pop;
  logic       link_ok;
  kfr_word_t  word;

  // A word is taken whenever the queue has a free slot.
  assign in_ch.ready = (count_r != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the incoming byte.
  assign link_ok = ({1'b0, in_ch.link} < (LINK_W + 1)'(NUM_LINKS));
  always_comb begin
    word.link     = in_ch.link;
    word.rx_byte  = in_ch.rx_byte;
    word.is_fend  = (in_ch.rx_byte == CH_FEND);
    word.is_fesc  = (in_ch.rx_byte == CH_FESC);
    word.is_tfend = (in_ch.rx_byte == CH_TFEND);
    word.is_tfesc = (in_ch.rx_byte == CH_TFESC);
  end

  assign push = accept && link_ok;
  assign pop  = q_pop && (count_r != 2'd0);

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= word;
    end
  end

  assign q_valid = (count_r != 2'd0);
  assign q_word  = mem_r[rd_ptr_r];

endmodule

@@ rtl/kfr_back.sv @@
// ============================================================================
// KISS frame receiver back end
// Keeps the per-link receive state, removes stuffing, tracks the command
// byte and ackmode id, and registers the resulting event word.
// ============================================================================
module kfr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  kfr_pkg::kfr_word_t q_word,
  output logic               q_pop,
  kfr_out_if.source          out_ch
);
  import kfr_pkg::*;

  // Per-link state.
  logic [1:0]         mode_r [NUM_LINKS];
  logic [COUNT_W-1:0] cnt_r  [NUM_LINKS];
  logic [BYTE_W-1:0]  cmd_r  [NUM_LINKS];
  logic [ID_W-1:0]    aid_r  [NUM_LINKS];

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [BYTE_W-1:0] pay_r, pay_nxt;
  logic              ack_r, ack_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  logic [LINK_IDX_W-1:0] l;
  logic [1:0]            mode, mode_nxt;
  logic [COUNT_W-1:0]    cnt, cnt_nxt, cnt_e;
  logic [BYTE_W-1:0]     cmd, cmd_nxt;
  logic [ID_W-1:0]       aid, aid_nxt;
  logic                  do_store;
  logic [BYTE_W-1:0]     sbyte;
  logic [3:0]            nib;
  logic                  emit;
  logic [KIND_W-1:0]     kind;
  logic [BYTE_W-1:0]     pay;

  // A word is processed whenever the output register is free or draining.
  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  assign l    = q_word.link[LINK_IDX_W-1:0];
  assign mode = mode_r[l];
  assign cnt  = cnt_r[l];
  assign cmd  = cmd_r[l];
  assign aid  = aid_r[l];

  // Unstuffing and frame tracking for the selected link.
  always_comb begin
    mode_nxt = mode;
    cnt_nxt  = cnt;
    cmd_nxt  = cmd;
    aid_nxt  = aid;
    do_store = 1'b0;
    sbyte    = q_word.rx_byte;
    emit     = 1'b0;
    kind     = EV_PAYLOAD;
    pay      = '0;
    nib      = cmd[3:0];

    unique case (mode)
      MODE_DATA: begin
        if (q_word.is_fend) begin
          // Closing delimiter: report the frame unless it was empty.
          if (cnt != '0) begin
            emit = 1'b1;
            if (nib == CMD_DATA) begin
              kind = EV_END;
            end else if (nib == CMD_ACK) begin
              kind = (cnt < COUNT_W'(3)) ? EV_SHORT : EV_END;
            end else begin
              kind = EV_UNKNOWN;
            end
          end
          cnt_nxt  = '0;
          mode_nxt = MODE_DATA;
        end else if (q_word.is_fesc) begin
          mode_nxt = MODE_ESC;
        end else begin
          do_store = 1'b1;
        end
      end
      MODE_ESC: begin
        if (q_word.is_tfend) begin
          do_store = 1'b1;
          sbyte    = CH_FEND;
        end else if (q_word.is_tfesc) begin
          do_store = 1'b1;
          sbyte    = CH_FESC;
        end else begin
          mode_nxt = MODE_DATA;
          emit     = 1'b1;
          kind     = EV_BADESC;
        end
      end
      default: begin
        if (q_word.is_fend) begin
          mode_nxt = MODE_DATA;
          cnt_nxt  = '0;
        end
      end
    endcase

    // Store one unstuffed byte: command, ackmode id or payload.
    if (do_store) begin
      if (cnt == '0) begin
        cmd_nxt = sbyte;
      end
      nib = cmd_nxt[3:0];
      if (nib == CMD_ACK && cnt == COUNT_W'(1)) begin
        aid_nxt[15:8] = sbyte;
      end else if (nib == CMD_ACK && cnt == COUNT_W'(2)) begin
        aid_nxt[7:0] = sbyte;
      end
      cnt_nxt = cnt + COUNT_W'(1);
      if (cnt_nxt >= COUNT_W'(FRAME_LIMIT)) begin
        mode_nxt = MODE_WAIT;
        emit     = 1'b1;
        kind     = EV_OVERRUN;
      end else begin
        mode_nxt = MODE_DATA;
        if ((nib == CMD_DATA && cnt >= COUNT_W'(1)) ||
            (nib == CMD_ACK && cnt >= COUNT_W'(3))) begin
          emit = 1'b1;
          kind = EV_PAYLOAD;
          pay  = sbyte;
        end
      end
    end
  end

  // Event fields follow the state as it stands after the byte.
  assign cnt_e = do_store ? cnt_nxt : cnt;

  always_comb begin
    port_nxt = {q_word.link, 4'd0};
    ack_nxt  = 1'b0;
    id_nxt   = '0;
    if (cnt_e != '0) begin
      port_nxt = {q_word.link, cmd_nxt[7:4]};
      if (cmd_nxt[3:0] == CMD_ACK && cnt_e >= COUNT_W'(3)) begin
        ack_nxt = 1'b1;
        id_nxt  = aid_nxt;
      end
    end
    kind_nxt = kind;
    pay_nxt  = pay;
  end

  // Output valid: loaded on a processed word, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LINKS; i++) begin
        mode_r[i] <= MODE_WAIT;
        cnt_r[i]  <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        mode_r[l] <= mode_nxt;
        cnt_r[l]  <= cnt_nxt;
      end
    end
  end

  // Payload state and event register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r[l] <= cmd_nxt;
      aid_r[l] <= aid_nxt;
      if (emit) begin
        kind_r <= kind_nxt;
        port_r <= port_nxt;
        pay_r  <= pay_nxt;
        ack_r  <= ack_nxt;
        id_r   <= id_nxt;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = kind_r;
  assign out_ch.port         = port_r;
  assign out_ch.payload_byte = pay_r;
  assign out_ch.is_ackmode   = ack_r;
  assign out_ch.frame_id     = id_r;

endmodule

@@ rtl/kiss_frame_receiver_core.sv @@
// ============================================================================
// KISS frame receiver core
// Deframes KISS byte streams from several serial links into event words.
// ============================================================================
// The block takes one received byte per clock cycle while its queue has a
// free slot and gives at most one event word per byte. A byte passes a
// two-word queue and then the per-link state update, a read-modify-write of
// the link's mode, count, command byte and ackmode id, whose event is held
// in a registered output; a new byte may follow in every cycle while that
// output is free or taken. Bytes of links at or above NUM_LINKS are
// accepted and dropped. Payload bytes stream out as they arrive; a consumer
// that sees an overrun abort discards the partial frame.
module kiss_frame_receiver_core (
  input logic        clk,
  input logic        rst_n,
  kfr_in_if.sink     in_ch,
  kfr_out_if.source  out_ch
);
  import kfr_pkg::*;

  logic      q_valid;
  logic      q_pop;
  kfr_word_t q_word;

  // Accept and classify.
  kfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  // Per-link deframing and event output.
  kfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ tb/kiss_frame_receiver_core_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// KISS frame receiver core testbench
// Drives received bytes from several links into the deframer with random
// pacing on both channels. An internal deframer model predicts each event
// word, and every word that arrives is checked against the oldest one.
// ============================================================================
module kiss_frame_receiver_core_tb;
  import kfr_pkg::*;

  // Served-link bytes to send before the stimulus stops.
  localparam int ITEMS    = 1850;
  // An ackmode frame carries its id once the command and two id bytes are in.
  localparam int ACK_HEAD = 3;
  localparam int DIR_ROWS = 25;

  // One event word as the checker sees it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [BYTE_W-1:0] data;
    logic              ack;
    logic [ID_W-1:0]   id;
  } ev_word_t;

  // How the expected event of a directed row is obtained.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_EVENT
  } row_kind_t;

  typedef struct {
    logic [LINK_W-1:0] link;
    logic [BYTE_W-1:0] data;
    row_kind_t         kind;
    ev_word_t          ev;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  kfr_in_if  in_ch ();
  kfr_out_if out_ch ();

  kiss_frame_receiver_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Per-link deframer state of the model.
  logic [1:0]        link_mode  [NUM_LINKS];
  int                link_count [NUM_LINKS];
  logic [BYTE_W-1:0] link_cmd   [NUM_LINKS];
  logic [ID_W-1:0]   link_id    [NUM_LINKS];

  ev_word_t pending_events [$];
  dir_row_t dir_plan [DIR_ROWS];

  // Byte streams under construction and the two links they are sent on.
  logic [BYTE_W-1:0] frame_q [$];
  logic [BYTE_W-1:0] frame_a [$];
  logic [BYTE_W-1:0] frame_b [$];
  logic [LINK_W-1:0] link_a;
  logic [LINK_W-1:0] link_b;

  // Expectation override of the word currently offered by the sender.
  row_kind_t row_kind_now;
  ev_word_t  row_ev_now;

  bit no_idle;
  int words_sent;
  int served_sent;
  int patterns;
  int events_seen;
  int fail_count;
  int kind_seen [8];
  int stall_left;
  int burst_left;

  // ---------------------------------------------------------------------------
  // Deframer model
  // ---------------------------------------------------------------------------

  // Event word for link l; unit and ackmode id come from the current frame.
  function automatic ev_word_t build_event(input logic [LINK_W-1:0] l,
                                           input logic [KIND_W-1:0] kind,
                                           input logic [BYTE_W-1:0] data);
    ev_word_t ev;
    ev      = '0;
    ev.kind = kind;
    ev.port = {l, 4'h0};
    ev.data = data;
    if (link_count[l] >= 1) begin
      ev.port[3:0] = link_cmd[l][7:4];
      if (link_cmd[l][3:0] == CMD_ACK && link_count[l] >= ACK_HEAD) begin
        ev.ack = 1'b1;
        ev.id  = link_id[l];
      end
    end
    return ev;
  endfunction

  // Stores one unstuffed byte in the frame of link l.
  function automatic bit store_unstuffed(input logic [LINK_W-1:0] l,
                                         input logic [BYTE_W-1:0] b,
                                         output ev_word_t ev);
    int         pos;
    logic [3:0] cmd;
    ev  = '0;
    pos = link_count[l];
    if (pos == 0) link_cmd[l] = b;
    cmd = link_cmd[l][3:0];
    if (cmd == CMD_ACK && pos == 1) link_id[l][15:8] = b;
    else if (cmd == CMD_ACK && pos == 2) link_id[l][7:0] = b;
    link_count[l] = pos + 1;
    // The byte that fills the buffer aborts the frame.
    if (link_count[l] >= FRAME_LIMIT) begin
      link_mode[l] = MODE_WAIT;
      ev = build_event(l, EV_OVERRUN, 8'h00);
      return 1'b1;
    end
    link_mode[l] = MODE_DATA;
    if ((cmd == CMD_DATA && pos >= 1) || (cmd == CMD_ACK && pos >= ACK_HEAD)) begin
      ev = build_event(l, EV_PAYLOAD, b);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Closing delimiter: report the frame, then open a new one.
  function automatic bit finish_frame(input logic [LINK_W-1:0] l, output ev_word_t ev);
    bit made;
    ev   = '0;
    made = 1'b0;
    if (link_count[l] >= 1) begin
      made = 1'b1;
      if (link_cmd[l][3:0] == CMD_DATA) begin
        ev = build_event(l, EV_END, 8'h00);
      end else if (link_cmd[l][3:0] == CMD_ACK) begin
        ev = build_event(l, (link_count[l] < ACK_HEAD) ? EV_SHORT : EV_END, 8'h00);
      end else begin
        ev = build_event(l, EV_UNKNOWN, 8'h00);
      end
    end
    link_count[l] = 0;
    link_mode[l]  = MODE_DATA;
    return made;
  endfunction

  // One received byte; returns 1 when it causes an event word.
  function automatic bit deframe_byte(input logic [LINK_W-1:0] l,
                                      input logic [BYTE_W-1:0] b,
                                      output ev_word_t ev);
    ev = '0;
    if (l >= NUM_LINKS) return 1'b0;
    case (link_mode[l])
      MODE_DATA: begin
        if (b == CH_FEND) return finish_frame(l, ev);
        if (b == CH_FESC) begin
          link_mode[l] = MODE_ESC;
          return 1'b0;
        end
        return store_unstuffed(l, b, ev);
      end
      MODE_ESC: begin
        if (b == CH_TFEND) return store_unstuffed(l, CH_FEND, ev);
        if (b == CH_TFESC) return store_unstuffed(l, CH_FESC, ev);
        // Any other byte after FESC is dropped and the frame goes on.
        link_mode[l] = MODE_DATA;
        ev = build_event(l, EV_BADESC, 8'h00);
        return 1'b1;
      end
      default: begin
        if (b == CH_FEND) begin
          link_mode[l]  = MODE_DATA;
          link_count[l] = 0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------------------

  function automatic dir_row_t quiet_row(input logic [LINK_W-1:0] l,
                                         input logic [BYTE_W-1:0] b);
    dir_row_t row;
    row = '{l, b, ROW_QUIET, '0};
    return row;
  endfunction

  function automatic dir_row_t event_row(input logic [LINK_W-1:0] l,
                                         input logic [BYTE_W-1:0] b,
                                         input logic [KIND_W-1:0] kind,
                                         input logic [PORT_W-1:0] port,
                                         input logic [BYTE_W-1:0] data);
    dir_row_t row;
    row = '{l, b, ROW_EVENT, '{kind, port, data, 1'b0, 16'h0000}};
    return row;
  endfunction

  function automatic dir_row_t check_row(input logic [LINK_W-1:0] l,
                                         input logic [BYTE_W-1:0] b);
    dir_row_t row;
    row = '{l, b, ROW_PREDICT, '0};
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  // Byte values with the KISS codes and the extremes well represented.
  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 11))
      0:       return CH_FEND;
      1:       return CH_FESC;
      2:       return CH_TFEND;
      3:       return CH_TFESC;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A byte that is not a legal escape follower, FEND often.
  function automatic logic [BYTE_W-1:0] bad_escape_byte();
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 2) == 0) return CH_FEND;
    b = 8'($urandom_range(0, 255));
    if (b == CH_TFEND || b == CH_TFESC) b = CH_FESC;
    return b;
  endfunction

  // Mostly data and ackmode commands with a random unit, some unknown ones.
  function automatic logic [BYTE_W-1:0] pick_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return {4'($urandom_range(0, 15)), CMD_DATA};
    if (pick < 85) return {4'($urandom_range(0, 15)), CMD_ACK};
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int frame_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 12);
    return $urandom_range(13, 48);
  endfunction

  function automatic int idle_gap();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic stuff_byte(input logic [BYTE_W-1:0] b);
    if (b == CH_FEND) begin
      frame_q.push_back(CH_FESC);
      frame_q.push_back(CH_TFEND);
    end else if (b == CH_FESC) begin
      frame_q.push_back(CH_FESC);
      frame_q.push_back(CH_TFESC);
    end else begin
      frame_q.push_back(b);
    end
  endtask

  // Stuffed frame into frame_q: leading FENDs, command, len bytes, closing FEND.
  task automatic build_frame(input int lead, input logic [BYTE_W-1:0] cmd, input int len);
    frame_q = {};
    repeat (lead) frame_q.push_back(CH_FEND);
    stuff_byte(cmd);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        frame_q.push_back(CH_FESC);
        frame_q.push_back(bad_escape_byte());
      end else begin
        stuff_byte(rand_byte());
      end
    end
    frame_q.push_back(CH_FEND);
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one word after a random gap and returns at the falling edge after
  // it was accepted, leaving valid high.
  task automatic send_word(input logic [LINK_W-1:0] l, input logic [BYTE_W-1:0] b,
                           input row_kind_t rk, input ev_word_t rev);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.link    <= l;
    in_ch.rx_byte <= b;
    row_kind_now = rk;
    row_ev_now   = rev;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (l < NUM_LINKS) served_sent++;
  endtask

  // Interleaves frame_a and frame_b, with stray bytes on unserved links.
  task automatic play_streams();
    bit take_a;
    while (frame_a.size() != 0 || frame_b.size() != 0) begin
      if (NUM_LINKS < 16 && $urandom_range(0, 24) == 0) begin
        send_word(4'($urandom_range(NUM_LINKS, 15)), rand_byte(), ROW_PREDICT, '0);
      end else begin
        take_a = (frame_b.size() == 0) ||
                 (frame_a.size() != 0 && $urandom_range(0, 1) == 0);
        if (take_a) send_word(link_a, frame_a.pop_front(), ROW_PREDICT, '0);
        else send_word(link_b, frame_b.pop_front(), ROW_PREDICT, '0);
      end
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: bursts of full rate, short stalls and a few long ones.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : result_pacing
    int pick;
    if (burst_left > 0) begin
      out_ch.ready <= 1'b1;
      burst_left--;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        out_ch.ready <= 1'b1;
        burst_left = $urandom_range(20, 120);
      end else if (pick < 72) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(5, 40);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction on each accepted byte and checking of each event word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : event_check
    ev_word_t want;
    ev_word_t got;
    bit       made;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        made = deframe_byte(in_ch.link, in_ch.rx_byte, want);
        if (row_kind_now == ROW_QUIET) begin
          made = 1'b0;
        end else if (row_kind_now == ROW_EVENT) begin
          made = 1'b1;
          want = row_ev_now;
        end
        if (made) pending_events.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.event_kind, out_ch.port, out_ch.payload_byte,
                out_ch.is_ackmode, out_ch.frame_id};
        events_seen++;
        kind_seen[got.kind]++;
        if (pending_events.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected event word: kind=%0d port=%02h byte=%02h ack=%0b id=%04h",
                     got.kind, got.port, got.data, got.ack, got.id);
        end else begin
          want = pending_events.pop_front();
          if (got.kind !== want.kind || got.port !== want.port || got.data !== want.data ||
              got.ack !== want.ack || got.id !== want.id) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Event %0d mismatch: expected kind=%0d port=%02h byte=%02h %s",
                       events_seen, want.kind, want.port, want.data,
                       $sformatf("ack=%0b id=%04h", want.ack, want.id));
              $display("  got kind=%0d port=%02h byte=%02h ack=%0b id=%04h",
                       got.kind, got.port, got.data, got.ack, got.id);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int pick;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.link    = '0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    row_kind_now  = ROW_PREDICT;
    row_ev_now    = '0;
    no_idle       = 1'b0;
    for (int i = 0; i < NUM_LINKS; i++) begin
      link_mode[i]  = MODE_WAIT;
      link_count[i] = 0;
      link_cmd[i]   = '0;
      link_id[i]    = '0;
    end

    // Directed frames: waiting state, unserved link, empty frame, data frame
    // with both escapes and a bad escape on FEND, interleaved ackmode frames,
    // a short ackmode frame and an unknown command.
    dir_plan[0]  = quiet_row(4'd0, 8'h41);
    dir_plan[1]  = quiet_row(4'd15, CH_FEND);
    dir_plan[2]  = quiet_row(4'd0, CH_FEND);
    dir_plan[3]  = quiet_row(4'd0, CH_FEND);
    dir_plan[4]  = quiet_row(4'd0, 8'hF0);
    dir_plan[5]  = event_row(4'd0, 8'h00, EV_PAYLOAD, 8'h0F, 8'h00);
    dir_plan[6]  = event_row(4'd0, 8'hFF, EV_PAYLOAD, 8'h0F, 8'hFF);
    dir_plan[7]  = quiet_row(4'd0, CH_FESC);
    dir_plan[8]  = check_row(4'd0, CH_TFEND);
    dir_plan[9]  = check_row(4'd0, CH_FESC);
    dir_plan[10] = check_row(4'd0, CH_TFESC);
    dir_plan[11] = check_row(4'd0, CH_FESC);
    dir_plan[12] = event_row(4'd0, CH_FEND, EV_BADESC, 8'h0F, 8'h00);
    dir_plan[13] = event_row(4'd0, CH_FEND, EV_END, 8'h0F, 8'h00);
    dir_plan[14] = quiet_row(4'd3, CH_FEND);
    dir_plan[15] = quiet_row(4'd3, 8'h5C);
    dir_plan[16] = quiet_row(4'd3, 8'h12);
    dir_plan[17] = quiet_row(4'd1, CH_FEND);
    dir_plan[18] = quiet_row(4'd3, 8'h34);
    dir_plan[19] = check_row(4'd3, 8'hAB);
    dir_plan[20] = quiet_row(4'd1, 8'h7C);
    dir_plan[21] = event_row(4'd1, CH_FEND, EV_SHORT, 8'h17, 8'h00);
    dir_plan[22] = quiet_row(4'd1, 8'h03);
    dir_plan[23] = event_row(4'd1, CH_FEND, EV_UNKNOWN, 8'h10, 8'h00);
    dir_plan[24] = check_row(4'd3, CH_FEND);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_plan[i].link, dir_plan[i].data, dir_plan[i].kind, dir_plan[i].ev);
    wait_drained();

    // Random traffic: mostly pairs of interleaved well-formed frames, plus
    // noise and broken frames. One long frame stays under the buffer limit, a later one overruns.
    while (served_sent < ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      link_a  = 4'($urandom_range(0, NUM_LINKS - 1));
      link_b  = (NUM_LINKS > 1) ?
                4'((link_a + $urandom_range(1, NUM_LINKS - 1)) % NUM_LINKS) : link_a;
      frame_b = {};
      pick    = $urandom_range(0, 99);
      if (patterns == 6 || patterns == 18) begin
        // Longest frame that still closes normally, later one that overruns.
        if (patterns == 6)
          build_frame(2, {4'($urandom_range(0, 15)), CMD_DATA}, FRAME_LIMIT - 2);
        else
          build_frame(2, {4'($urandom_range(0, 15)), CMD_ACK}, FRAME_LIMIT + 4);
        frame_a = frame_q;
        build_frame(0, pick_command(), frame_len());
        frame_b = frame_q;
      end else if (pick < 75) begin
        build_frame(($urandom_range(0, 3) == 0) ? 1 : 0, pick_command(), frame_len());
        frame_a = frame_q;
        build_frame(($urandom_range(0, 3) == 0) ? 1 : 0, pick_command(), frame_len());
        frame_b = frame_q;
      end else if (pick < 88) begin
        // Noise on any link number.
        link_a  = 4'($urandom_range(0, 15));
        frame_a = {};
        repeat ($urandom_range(1, 8)) frame_a.push_back(rand_byte());
      end else begin
        // Broken frame: closing FEND lost, or turned into a bad escape.
        build_frame(0, pick_command(), frame_len());
        frame_a = frame_q;
        if ($urandom_range(0, 1) == 1) void'(frame_a.pop_back());
        else frame_a.insert(frame_a.size() - 1, CH_FESC);
      end
      play_streams();
      patterns++;
      if (patterns % 40 == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_events.size() != 0) begin
      fail_count++;
      $display("%0d expected event words never arrived", pending_events.size());
    end

    $display("Sent %0d bytes (%0d on served links) in %0d random patterns; %0d events checked.",
             words_sent, served_sent, patterns, events_seen);
    $display("Events: payload %0d, end %0d, overrun %0d, short ackmode %0d,",
             kind_seen[EV_PAYLOAD], kind_seen[EV_END], kind_seen[EV_OVERRUN],
             kind_seen[EV_SHORT]);
    $display("        unknown %0d, bad escape %0d.",
             kind_seen[EV_UNKNOWN], kind_seen[EV_BADESC]);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3ms;
    $display("Timeout with %0d event words outstanding", pending_events.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kfr_pkg.sv
rtl/kfr_if.sv
rtl/kfr_front.sv
rtl/kfr_back.sv
rtl/kiss_frame_receiver_core.sv
tb/kiss_frame_receiver_core_tb.sv
